[rtl/core/frame_rate_fault_monitor_core_defines.svh]
// ----------------------------------------------------------------------------
// frame rate fault monitor assertion macros
// shared concurrent assertion forms, clocked on aclk, held off during reset
// ----------------------------------------------------------------------------
`ifndef FRAME_RATE_FAULT_MONITOR_CORE_DEFINES_SVH
`define FRAME_RATE_FAULT_MONITOR_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FRFM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define FRFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/frfm_pkg.sv]
// ----------------------------------------------------------------------------
// frfm_pkg
// widths, constants and register codes of the frame rate fault monitor
// ----------------------------------------------------------------------------
`default_nettype none

package frfm_pkg;

    // field widths
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned TIME_W    = 64;
    localparam int unsigned FPS_W     = 10;
    localparam int unsigned BAND_W    = 8;
    localparam int unsigned PERIOD_W  = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // stream widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = ((COUNT_W + TIME_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W = 8;

    // rate bounds are signed: expected +/- band
    localparam int unsigned K_W    = 12;
    // microseconds per second and its signed width
    localparam int unsigned USEC_W = 21;
    localparam logic [USEC_W-1:0] US_PER_SEC = USEC_W'(1000000);
    // scaled count difference and scaled bound widths
    localparam int unsigned SCALED_W = COUNT_W + USEC_W;
    localparam int unsigned BOUND_W  = K_W + TIME_W + 1;

    // register reset values
    localparam logic [FPS_W-1:0]    EXPECTED_FPS_RST  = FPS_W'(30);
    localparam logic [BAND_W-1:0]   FAULT_BAND_RST    = BAND_W'(3);
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_US_RST = PERIOD_W'(1000000);

    // result word bit positions
    localparam int unsigned OUT_FAULT_BIT    = 0;
    localparam int unsigned OUT_CHANGED_BIT  = 1;
    localparam int unsigned OUT_MEASURED_BIT = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_FPS  = 2'd0,
        CFG_FAULT_BAND    = 2'd1,
        CFG_MIN_PERIOD_US = 2'd2
    } cfg_index_t;

endpackage

`default_nettype wire

[rtl/core/frame_rate_fault_monitor_core.sv]
// ----------------------------------------------------------------------------
// frame_rate_fault_monitor_core
// checks sensor frame rate against a tolerance band around the expected rate
// ----------------------------------------------------------------------------
//  channel  direction  ports                   word contents
//  s_       in         s_tvalid/tready/tdata   frame_count, time_us
//  m_       out        m_tvalid/tready/tdata   rate_fault, fault_changed,
//                                              rate_measured
//  cfg_     in         cfg_valid/ready/index   expected_fps, fault_band,
//                      cfg_data                min_period_us
//
//  one word accepted per cycle unless the result stream stalls; a result passes
//  through four register stages: input, elapsed time, products, result
//  the reference update happens in the elapsed-time stage, the fault update in
//  the result stage, so consecutive words see the state left by earlier ones
//  aresetn clears valid bits, reference and fault state, and loads register resets
//  each stage holds when the one after it is full and stalled; bubbles fill in
// ----------------------------------------------------------------------------
`default_nettype none

module frame_rate_fault_monitor_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // slave word: [31:0] frame_count, [95:32] time_us
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [frfm_pkg::S_TDATA_W-1:0]    s_tdata,
    // master word: [0] rate_fault, [1] fault_changed, [2] rate_measured,
    // [7:3] zero
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [frfm_pkg::M_TDATA_W-1:0]         m_tdata,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [frfm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [frfm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int unsigned CW = frfm_pkg::COUNT_W;
    localparam int unsigned TW = frfm_pkg::TIME_W;

    // configuration registers
    logic [frfm_pkg::FPS_W-1:0]    expected_fps_reg;
    logic [frfm_pkg::BAND_W-1:0]   fault_band_reg;
    logic [frfm_pkg::PERIOD_W-1:0] min_period_us_reg;

    // monitor state
    logic          primed_reg;
    logic [CW-1:0] ref_count_reg;
    logic [TW-1:0] ref_time_reg;
    logic          fault_state_reg;

    // input stage
    logic          in_valid_reg;
    logic [CW-1:0] in_count_reg;
    logic [TW-1:0] in_time_reg;

    // elapsed-time stage
    logic          dt_valid_reg;
    logic          dt_meas_reg;
    logic [CW-1:0] dt_diff_reg;
    logic [TW-1:0] dt_time_reg;
    logic          dt_meas_next;
    logic [TW-1:0] dt_time_next;

    // product stage
    logic                                  mul_valid_reg;
    logic                                  mul_meas_reg;
    logic signed [frfm_pkg::SCALED_W-1:0]  mul_scaled_reg;
    logic signed [frfm_pkg::BOUND_W-1:0]   mul_low_reg;
    logic signed [frfm_pkg::BOUND_W-1:0]   mul_high_reg;
    logic signed [frfm_pkg::SCALED_W-1:0]  mul_scaled_next;
    logic signed [frfm_pkg::BOUND_W-1:0]   mul_low_next;
    logic signed [frfm_pkg::BOUND_W-1:0]   mul_high_next;
    logic signed [frfm_pkg::K_W-1:0]       low_k;
    logic signed [frfm_pkg::K_W-1:0]       high_k;

    // result stage
    logic m_valid_reg;
    logic out_fault_reg;
    logic out_changed_reg;
    logic out_meas_reg;
    logic fault_next;

    // stage movement
    logic mov_out;
    logic mov_mul;
    logic mov_dt;
    logic mul_room;
    logic dt_room;

    assign mov_out  = mul_valid_reg && (!m_valid_reg || m_tready);
    assign mul_room = !mul_valid_reg || mov_out;
    assign mov_mul  = dt_valid_reg && mul_room;
    assign dt_room  = !dt_valid_reg || mov_mul;
    assign mov_dt   = in_valid_reg && dt_room;
    assign s_tready = !in_valid_reg || mov_dt;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_fps_reg  <= frfm_pkg::EXPECTED_FPS_RST;
            fault_band_reg    <= frfm_pkg::FAULT_BAND_RST;
            min_period_us_reg <= frfm_pkg::MIN_PERIOD_US_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                frfm_pkg::CFG_EXPECTED_FPS:
                    expected_fps_reg <= cfg_data[frfm_pkg::FPS_W-1:0];
                frfm_pkg::CFG_FAULT_BAND:
                    fault_band_reg <= cfg_data[frfm_pkg::BAND_W-1:0];
                frfm_pkg::CFG_MIN_PERIOD_US:
                    min_period_us_reg <= cfg_data[frfm_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_count_reg <= s_tdata[CW-1:0];
            in_time_reg  <= s_tdata[CW+TW-1:CW];
        end
    end

    // elapsed time and interval check against the reference
    always_comb begin
        dt_time_next = in_time_reg - ref_time_reg;
        dt_meas_next = primed_reg && (dt_time_next > TW'(min_period_us_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_valid_reg  <= 1'b0;
            primed_reg    <= 1'b0;
            ref_count_reg <= '0;
            ref_time_reg  <= '0;
        end else begin
            if (dt_room) begin
                dt_valid_reg <= in_valid_reg;
            end
            // first word primes, a long enough interval moves the reference
            if (mov_dt && (!primed_reg || dt_meas_next)) begin
                primed_reg    <= 1'b1;
                ref_count_reg <= in_count_reg;
                ref_time_reg  <= in_time_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mov_dt) begin
            dt_meas_reg <= dt_meas_next;
            dt_diff_reg <= in_count_reg - ref_count_reg;
            dt_time_reg <= dt_time_next;
        end
    end

    // band bounds and cross products
    always_comb begin
        low_k  = $signed({2'b00, expected_fps_reg}) - $signed({4'b0000, fault_band_reg});
        high_k = $signed({2'b00, expected_fps_reg}) + $signed({4'b0000, fault_band_reg});
        mul_scaled_next = $signed(dt_diff_reg) * $signed(frfm_pkg::US_PER_SEC);
        mul_low_next    = low_k * $signed({1'b0, dt_time_reg});
        mul_high_next   = high_k * $signed({1'b0, dt_time_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (mul_room) begin
            mul_valid_reg <= dt_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mov_mul) begin
            mul_meas_reg   <= dt_meas_reg;
            mul_scaled_reg <= mul_scaled_next;
            mul_low_reg    <= mul_low_next;
            mul_high_reg   <= mul_high_next;
        end
    end

    // band compare; an unmeasured word keeps the fault as it stands
    always_comb begin
        if (mul_meas_reg) begin
            fault_next = (frfm_pkg::BOUND_W'(mul_scaled_reg) < mul_low_reg) ||
                         (frfm_pkg::BOUND_W'(mul_scaled_reg) > mul_high_reg);
        end else begin
            fault_next = fault_state_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            fault_state_reg <= 1'b0;
        end else begin
            if (mov_out) begin
                m_valid_reg     <= 1'b1;
                fault_state_reg <= fault_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mov_out) begin
            out_fault_reg   <= fault_next;
            out_changed_reg <= fault_next != fault_state_reg;
            out_meas_reg    <= mul_meas_reg;
        end
    end

    // result word
    always_comb begin
        m_tdata = '0;
        m_tdata[frfm_pkg::OUT_FAULT_BIT]    = out_fault_reg;
        m_tdata[frfm_pkg::OUT_CHANGED_BIT]  = out_changed_reg;
        m_tdata[frfm_pkg::OUT_MEASURED_BIT] = out_meas_reg;
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

[rtl/core/frfm_checker.sv]
// ----------------------------------------------------------------------------
// frfm_checker
// port-level checks of the frame rate fault monitor result stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_rate_fault_monitor_core_defines.svh"

module frfm_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [frfm_pkg::M_TDATA_W-1:0]    m_tdata
);

    logic last_fault_reg;
    logic w_fault;
    logic w_changed;
    logic w_meas;

    assign w_fault   = m_tdata[frfm_pkg::OUT_FAULT_BIT];
    assign w_changed = m_tdata[frfm_pkg::OUT_CHANGED_BIT];
    assign w_meas    = m_tdata[frfm_pkg::OUT_MEASURED_BIT];

    // fault level of the last delivered word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_fault_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            last_fault_reg <= w_fault;
        end
    end

    `FRFM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
    `FRFM_ASSERT_SAME(a_change_needs_meas, m_tvalid && w_changed, w_meas, "fault change without a measurement")
    `FRFM_ASSERT_SAME(a_unmeasured_keeps, m_tvalid && !w_meas, w_fault == last_fault_reg, "fault moved on an unmeasured word")
    `FRFM_ASSERT_SAME(a_change_flag, m_tvalid && w_meas, w_changed == (w_fault != last_fault_reg), "change flag disagrees with fault history")

endmodule

bind frame_rate_fault_monitor_core frfm_checker u_frfm_checker (.*);

`default_nettype wire

[verif/frame_rate_fault_monitor_core_tb.sv]
// ----------------------------------------------------------------------------
// frame_rate_fault_monitor_core_tb
// streams timestamped frame counter samples into the monitor and checks each
// result word against an exact in-bench model of the rate band; directed
// cases first, then paced and noisy traffic over several register settings
// with random idle and stall bursts on both streams
// ----------------------------------------------------------------------------

module frame_rate_fault_monitor_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import frfm_pkg::*;

    // unused register index, writes to it must have no effect
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam logic [63:0]          USEC_PER_SEC  = 64'd1000000;
    localparam int unsigned          QUIET_LIMIT   = 4000;
    localparam int unsigned          TAIL_CYCLES   = 12;
    localparam int unsigned          PHASE_WORDS   = 115;

    typedef struct packed {
        logic fault;
        logic changed;
        logic measured;
    } verdict_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // model registers and reference state
    logic [FPS_W-1:0]    fps_q    = EXPECTED_FPS_RST;
    logic [BAND_W-1:0]   band_q   = FAULT_BAND_RST;
    logic [PERIOD_W-1:0] period_q = MIN_PERIOD_US_RST;
    logic                primed_q    = 1'b0;
    logic [COUNT_W-1:0]  ref_count_q = '0;
    logic [TIME_W-1:0]   ref_time_q  = '0;
    logic                fault_q     = 1'b0;

    verdict_t    pending_verdicts[$];
    int unsigned fail_count  = 0;
    int unsigned quiet_count = 0;
    bit          idle_en     = 1'b1;

    frame_rate_fault_monitor_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // exact rate band evaluation of one sample, updates the model state
    function automatic verdict_t evaluate_frame_rate(input logic [COUNT_W-1:0] cnt,
                                                     input logic [TIME_W-1:0] t);
        verdict_t           v;
        logic [TIME_W-1:0]  dt;
        logic [COUNT_W-1:0] du;
        logic signed [127:0] scaled;
        logic signed [127:0] dt_w;
        logic signed [127:0] low_lim;
        logic signed [127:0] high_lim;
        int                 lowk;
        int                 highk;
        logic               was_fault;
        was_fault  = fault_q;
        v.measured = 1'b0;
        if (!primed_q) begin
            primed_q    = 1'b1;
            ref_count_q = cnt;
            ref_time_q  = t;
        end else begin
            dt = t - ref_time_q;
            if (dt > {32'd0, period_q}) begin
                du       = cnt - ref_count_q;
                scaled   = $signed(du);
                scaled   = scaled * 128'sd1000000;
                lowk     = int'(fps_q) - int'(band_q);
                highk    = int'(fps_q) + int'(band_q);
                dt_w     = $signed({64'd0, dt});
                low_lim  = lowk;
                low_lim  = low_lim * dt_w;
                high_lim = highk;
                high_lim = high_lim * dt_w;
                fault_q  = (scaled < low_lim) || (scaled > high_lim);
                v.measured  = 1'b1;
                ref_count_q = cnt;
                ref_time_q  = t;
            end
        end
        v.fault   = fault_q;
        v.changed = (fault_q != was_fault);
        return v;
    endfunction

    // send one sample word and queue its expected verdict
    task automatic send_sample(input logic [COUNT_W-1:0] cnt, input logic [TIME_W-1:0] t);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t, cnt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_verdicts.push_back(evaluate_frame_rate(cnt, t));
    endtask

    // sample relative to the current reference
    task automatic send_rel(input logic [COUNT_W-1:0] dcount, input logic [TIME_W-1:0] dt);
        send_sample(ref_count_q + dcount, ref_time_q + dt);
    endtask

    // stop sending and wait until every result word is back
    task automatic quiesce();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_verdicts.size() != 0);
    endtask

    // one register write, valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_EXPECTED_FPS:  fps_q    = value[FPS_W-1:0];
            CFG_FAULT_BAND:    band_q   = value[BAND_W-1:0];
            CFG_MIN_PERIOD_US: period_q = value[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] fps_word,
                              input logic [CFG_DATA_W-1:0] band_word,
                              input logic [CFG_DATA_W-1:0] period_word);
        write_reg(CFG_EXPECTED_FPS, fps_word);
        write_reg(CFG_FAULT_BAND, band_word);
        write_reg(CFG_MIN_PERIOD_US, period_word);
        cfg_valid <= 1'b0;
    endtask

    // well-formed sample: interval past the minimum, rate near the band edges or random
    task automatic send_paced_sample();
        logic [TIME_W-1:0]   dt;
        int                  rate;
        int                  jitter;
        int                  lo;
        int                  hi;
        logic signed [127:0] frames;
        lo = int'(fps_q) - int'(band_q);
        hi = int'(fps_q) + int'(band_q);
        dt = {32'd0, period_q} + 64'd1;
        case ($urandom_range(0, 3))
            0: ;
            1: dt = dt + $urandom_range(0, 200);
            2: dt = dt + $urandom_range(0, 3000000);
            default: dt = ({32'd0, period_q} / USEC_PER_SEC + 64'd1 + $urandom_range(0, 2))
                          * USEC_PER_SEC;
        endcase
        case ($urandom_range(0, 7))
            0: rate = lo - 1;
            1: rate = lo;
            2: rate = int'(fps_q);
            3: rate = hi;
            4: rate = hi + 1;
            5: rate = $urandom_range(0, 1400);
            6: rate = -int'($urandom_range(1, 300));
            default: rate = lo + int'($urandom_range(0, 2 * band_q));
        endcase
        frames = rate;
        frames = (frames * $signed({64'd0, dt})) / 128'sd1000000;
        jitter = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 2)) - 1;
        send_rel(frames[31:0] + jitter, dt);
    endtask

    // priming, short interval and band edges with the reset register values
    task automatic test_reset_config();
        send_sample(32'd0, 64'd0);
        send_rel(32'd10, 64'd1000000);
        send_rel(32'd30, 64'd1000001);
        send_rel(32'd40, 64'd1000001);
        send_rel(32'd27, 64'd1000001);
        send_rel(32'd66, 64'd2000000);
        send_rel(32'd54, 64'd2000000);
    endtask

    // counter wrap both ways, time at its maximum, wrapping and going back
    task automatic test_counter_and_time_wrap();
        send_rel(32'hFFFF_FF9C, 64'd2000000);
        send_sample(32'hFFFF_FFF0, ref_time_q + 64'd2000000);
        send_rel(32'd60, 64'd2000000);
        send_sample(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_rel(32'd60, 64'd2000000);
        send_sample(ref_count_q + 32'd30, 64'd5);
    endtask

    // band wider than the rate, zero rate and band, longest minimum period
    task automatic test_wide_band_and_zero_rate();
        quiesce();
        set_config(32'd2, 32'd255, 32'd0);
        send_rel(32'hFFFF_FF9C, 64'd1);
        send_rel(32'd0, 64'd1);
        send_rel(32'd257, 64'd1000000);
        send_rel(32'hFFFF_FF03, 64'd1000000);
        send_rel(32'hFFFF_FF02, 64'd1000000);
        quiesce();
        set_config(32'hFFFF_FC00, 32'hFFFF_FF00, 32'hFFFF_FFFF);
        send_rel(32'd0, 64'h1_0000_0000);
        send_rel(32'd1, 64'hFFFF_FFFF);
        send_rel(32'd1, 64'h1_0000_0000);
        send_rel(32'hFFFF_FFFF, 64'h1_0000_0001);
    endtask

    // largest rate and band, spare register index ignored
    task automatic test_register_extremes();
        quiesce();
        write_reg(CFG_SPARE_IDX, $urandom);
        set_config(32'd1023, 32'd255, 32'd1);
        send_rel(32'd1278, 64'd1000000);
        send_rel(32'd768, 64'd1000000);
        send_rel(32'd767, 64'd1000000);
    endtask

    // random phases over many settings, mostly paced samples
    task automatic test_random_traffic();
        int unsigned   phase;
        int unsigned   n;
        int unsigned   pick;
        logic [31:0]   fps_word;
        logic [31:0]   band_word;
        logic [31:0]   period_word;
        for (phase = 0; phase < 8; phase++) begin
            quiesce();
            idle_en = (phase != 7);
            case (phase)
                0: begin
                    fps_word = 32'd1; band_word = 32'd0; period_word = 32'd0;
                end
                1: begin
                    fps_word = 32'd1023; band_word = 32'd255; period_word = 32'hFFFF_FFFF;
                end
                default: begin
                    fps_word  = $urandom_range(0, 1023);
                    band_word = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 12);
                    case ($urandom_range(0, 2))
                        0: period_word = $urandom_range(0, 2000);
                        1: period_word = $urandom_range(0, 2000000);
                        default: period_word = $urandom;
                    endcase
                    // junk above the register width is dropped
                    if ($urandom_range(0, 3) == 0) fps_word = fps_word | ($urandom << FPS_W);
                    if ($urandom_range(0, 3) == 0) band_word = band_word | ($urandom << BAND_W);
                end
            endcase
            set_config(fps_word, band_word, period_word);
            for (n = 0; n < PHASE_WORDS; n++) begin
                // hold off until the pipeline has fully drained
                if (idle_en && $urandom_range(0, 59) == 0) quiesce();
                pick = $urandom_range(0, 19);
                if (pick < 15) begin
                    send_paced_sample();
                end else if (pick < 18 && period_q != 0) begin
                    send_sample($urandom, ref_time_q + $urandom_range(0, period_q));
                end else begin
                    send_sample($urandom, {$urandom, $urandom});
                end
            end
        end
    endtask

    // sink side stall bursts
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            if (idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %b actual %b", $time, name, want, got);
            fail_count++;
        end
    endtask

    // compare each result word with the oldest expected verdict
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t unexpected result word: expected none actual %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("rate_fault", want.fault, m_tdata[OUT_FAULT_BIT]);
                check_field("fault_changed", want.changed, m_tdata[OUT_CHANGED_BIT]);
                check_field("rate_measured", want.measured, m_tdata[OUT_MEASURED_BIT]);
                if (m_tdata[M_TDATA_W-1:OUT_MEASURED_BIT+1] !== '0) begin
                    $display("%0t mismatch padding: expected 0 actual %h", $time,
                             m_tdata[M_TDATA_W-1:OUT_MEASURED_BIT+1]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
            if (quiet_count >= QUIET_LIMIT) begin
                $display("%0t timeout with %0d results outstanding", $time,
                         pending_verdicts.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_config();
        test_counter_and_time_wrap();
        test_wide_band_and_zero_rate();
        test_register_extremes();
        test_random_traffic();
        quiesce();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[frame_rate_fault_monitor_core.f]
+incdir+rtl/core
rtl/core/frfm_pkg.sv
rtl/core/frame_rate_fault_monitor_core.sv
rtl/core/frfm_checker.sv
verif/frame_rate_fault_monitor_core_tb.sv
